FILE: design/lpdst_pkg.sv
package lpdst_pkg;

   localparam int ANGLE_COUNT = 360;
   localparam int MEAS_BYTES  = 5;
   localparam int MEAS_HELD   = MEAS_BYTES - 1;

   localparam int ANGLE_W     = 9;
   localparam int ANGLE_SUM_W = 10;
   localparam int DIST_W      = 16;
   localparam int QUAL_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int QANGLE_W    = 16;
   localparam int QMIN_W      = 6;
   localparam int DMIN_W      = 14;
   localparam int HDR_CNT_W   = 3;
   localparam int PKT_CNT_W   = 3;
   localparam int PKT_IDX_W   = 2;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int LUT_DEPTH   = 256;

   // offset that makes the biased query angle congruent to the signed one
   localparam int QUERY_BIAS = (ANGLE_COUNT - ((QANGLE_W'(1) << (QANGLE_W - 1)) % ANGLE_COUNT))
                               % ANGLE_COUNT;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_QUERY   = 1'b1;
   localparam logic KIND_MEAS  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_QUALITY_MIN       = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_MIN      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_DISTANCE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLBACK_QUALITY  = 8'd3;

   localparam logic [QMIN_W-1:0]        QUALITY_MIN_RESET       = 6'd10;
   localparam logic [DMIN_W-1:0]        DISTANCE_MIN_RESET      = 14'd100;
   localparam logic signed [DIST_W-1:0] FALLBACK_DISTANCE_RESET = 16'sd0;
   localparam logic [QUAL_W-1:0]        FALLBACK_QUALITY_RESET  = 8'd0;

   typedef struct packed {
      logic [QMIN_W-1:0]        quality_min;
      logic [DMIN_W-1:0]        distance_min;
      logic signed [DIST_W-1:0] fallback_distance;
      logic [QUAL_W-1:0]        fallback_quality;
   } cfg_type;

   typedef struct packed {
      logic                     wr_en;
      logic                     rd_en;
      logic [ANGLE_W-1:0]       addr;
      logic signed [DIST_W-1:0] distance;
      logic [QUAL_W-1:0]        qual;
   } tbl_req_type;

   typedef struct packed {
      logic clearing;
      logic free;
   } tbl_stat_type;

   typedef struct packed {
      logic                     valid;
      logic                     kind;
      logic [ANGLE_W-1:0]       angle;
      logic signed [DIST_W-1:0] distance;
      logic [QUAL_W-1:0]        qual;
   } res_type;

   typedef logic [ANGLE_W-1:0] angle_lut_type [LUT_DEPTH];

   // residue of (high byte * 256 + bias) for the biased query angle
   function automatic angle_lut_type build_angle_lut();
      angle_lut_type lut;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut[i] = ANGLE_W'((i * LUT_DEPTH + QUERY_BIAS) % ANGLE_COUNT);
      end
      return lut;
   endfunction

   localparam angle_lut_type ANGLE_LUT = build_angle_lut();

endpackage

FILE: design/lpdst_ifs.sv
interface lpdst_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      operation;
   logic [lpdst_pkg::BYTE_W-1:0]              byte_value;
   logic signed [lpdst_pkg::QANGLE_W-1:0]     query_angle;
   modport source (output valid, operation, byte_value, query_angle, input ready);
   modport sink (input valid, operation, byte_value, query_angle, output ready);
endinterface

interface lpdst_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      result_kind;
   logic [lpdst_pkg::ANGLE_W-1:0]             angle_deg;
   logic signed [lpdst_pkg::DIST_W-1:0]       distance_mm;
   logic [lpdst_pkg::QUAL_W-1:0]              quality_level;
   modport source (output valid, result_kind, angle_deg, distance_mm, quality_level,
                   input ready);
   modport sink (input valid, result_kind, angle_deg, distance_mm, quality_level,
                 output ready);
endinterface

interface lpdst_csr_if;
   logic                                      valid;
   logic                                      ready;
   logic [lpdst_pkg::CSR_IDX_W-1:0]           index;
   logic [lpdst_pkg::CSR_DATA_W-1:0]          wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

FILE: design/lpdst_csr.sv
module lpdst_csr (
   input  logic                clock,
   input  logic                reset,
   lpdst_csr_if.sink           csr_bus,
   output lpdst_pkg::cfg_type  cfg
);

   lpdst_pkg::cfg_type cfg_ff;
   lpdst_pkg::cfg_type cfg_in;
   logic               wr;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid && csr_bus.ready;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_bus.index)
            lpdst_pkg::CSR_QUALITY_MIN: begin
               cfg_in.quality_min = csr_bus.wdata[lpdst_pkg::QMIN_W-1:0];
            end
            lpdst_pkg::CSR_DISTANCE_MIN: begin
               cfg_in.distance_min = csr_bus.wdata[lpdst_pkg::DMIN_W-1:0];
            end
            lpdst_pkg::CSR_FALLBACK_DISTANCE: begin
               cfg_in.fallback_distance = signed'(csr_bus.wdata[lpdst_pkg::DIST_W-1:0]);
            end
            lpdst_pkg::CSR_FALLBACK_QUALITY: begin
               cfg_in.fallback_quality = csr_bus.wdata[lpdst_pkg::QUAL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quality_min       <= lpdst_pkg::QUALITY_MIN_RESET;
         cfg_ff.distance_min      <= lpdst_pkg::DISTANCE_MIN_RESET;
         cfg_ff.fallback_distance <= lpdst_pkg::FALLBACK_DISTANCE_RESET;
         cfg_ff.fallback_quality  <= lpdst_pkg::FALLBACK_QUALITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/lpdst_decode.sv
module lpdst_decode #(
   parameter int HEADER_BYTES = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   lpdst_req_if.sink                req_bus,
   input  lpdst_pkg::cfg_type       cfg,
   input  lpdst_pkg::tbl_stat_type  tbl_stat,
   output lpdst_pkg::tbl_req_type   tbl_req
);

   logic                                  s1_valid_ff, s1_valid_in;
   logic                                  s1_op_ff;
   logic [lpdst_pkg::BYTE_W-1:0]          s1_byte_ff;
   logic signed [lpdst_pkg::QANGLE_W-1:0] s1_angle_ff;

   logic [lpdst_pkg::HDR_CNT_W-1:0]       hdr_ff, hdr_in;
   logic [lpdst_pkg::PKT_CNT_W-1:0]       pkt_ff, pkt_in;
   logic [lpdst_pkg::BYTE_W-1:0]          pkt_bytes_ff [lpdst_pkg::MEAS_HELD];

   logic                                  accept;
   logic                                  s1_go;
   logic                                  byte_go;
   logic                                  in_header;
   logic                                  in_packet;
   logic                                  meas_done;

   logic [lpdst_pkg::QMIN_W-1:0]          quality;
   logic [lpdst_pkg::ANGLE_W-1:0]         angle_field;
   logic [lpdst_pkg::ANGLE_W-1:0]         meas_angle;
   logic [lpdst_pkg::DMIN_W-1:0]          dist_raw;
   logic signed [lpdst_pkg::DIST_W-1:0]   meas_dist;

   logic [lpdst_pkg::QANGLE_W-1:0]        q_biased;
   logic [lpdst_pkg::ANGLE_SUM_W-1:0]     q_sum;
   logic [lpdst_pkg::ANGLE_W-1:0]         q_angle;

   assign req_bus.ready = !tbl_stat.clearing && (!s1_valid_ff || tbl_stat.free);
   assign accept        = req_bus.valid && req_bus.ready;
   assign s1_go         = s1_valid_ff && tbl_stat.free;
   assign s1_valid_in   = accept || (s1_valid_ff && !s1_go);

   assign byte_go   = s1_go && (s1_op_ff == lpdst_pkg::OP_BYTE);
   assign in_header = hdr_ff < lpdst_pkg::HDR_CNT_W'(HEADER_BYTES);
   assign in_packet = pkt_ff < lpdst_pkg::PKT_CNT_W'(lpdst_pkg::MEAS_HELD);
   assign meas_done = byte_go && !in_header && !in_packet;

   // measurement fields
   assign quality     = pkt_bytes_ff[0][lpdst_pkg::BYTE_W-1:2];
   assign angle_field = {pkt_bytes_ff[2], pkt_bytes_ff[1][lpdst_pkg::BYTE_W-1]};
   assign dist_raw    = {s1_byte_ff, pkt_bytes_ff[3][lpdst_pkg::BYTE_W-1:2]};

   always_comb begin
      if (angle_field == '0) begin
         meas_angle = '0;
      end else if ({1'b0, angle_field} <= lpdst_pkg::ANGLE_SUM_W'(lpdst_pkg::ANGLE_COUNT)) begin
         meas_angle = lpdst_pkg::ANGLE_W'(lpdst_pkg::ANGLE_SUM_W'(lpdst_pkg::ANGLE_COUNT)
                                          - {1'b0, angle_field});
      end else begin
         meas_angle = lpdst_pkg::ANGLE_W'(lpdst_pkg::ANGLE_SUM_W'(2 * lpdst_pkg::ANGLE_COUNT)
                                          - {1'b0, angle_field});
      end
   end

   always_comb begin
      if (quality < cfg.quality_min || dist_raw < cfg.distance_min) begin
         meas_dist = cfg.fallback_distance;
      end else begin
         meas_dist = signed'({2'b00, dist_raw});
      end
   end

   // query angle: bias to unsigned, table for the high byte, one fold
   assign q_biased = {~s1_angle_ff[lpdst_pkg::QANGLE_W-1], s1_angle_ff[lpdst_pkg::QANGLE_W-2:0]};
   assign q_sum    = {1'b0, lpdst_pkg::ANGLE_LUT[q_biased[lpdst_pkg::QANGLE_W-1:lpdst_pkg::BYTE_W]]}
                     + lpdst_pkg::ANGLE_SUM_W'(q_biased[lpdst_pkg::BYTE_W-1:0]);

   always_comb begin
      if (q_sum >= lpdst_pkg::ANGLE_SUM_W'(lpdst_pkg::ANGLE_COUNT)) begin
         q_angle = lpdst_pkg::ANGLE_W'(q_sum - lpdst_pkg::ANGLE_SUM_W'(lpdst_pkg::ANGLE_COUNT));
      end else begin
         q_angle = lpdst_pkg::ANGLE_W'(q_sum);
      end
   end

   always_comb begin
      tbl_req.wr_en    = meas_done;
      tbl_req.rd_en    = s1_go && (s1_op_ff == lpdst_pkg::OP_QUERY);
      tbl_req.addr     = (s1_op_ff == lpdst_pkg::OP_QUERY) ? q_angle : meas_angle;
      tbl_req.distance = meas_dist;
      tbl_req.qual     = lpdst_pkg::QUAL_W'(quality);
   end

   always_comb begin
      hdr_in = hdr_ff;
      pkt_in = pkt_ff;
      if (byte_go) begin
         if (in_header) begin
            hdr_in = hdr_ff + 1'b1;
         end else if (in_packet) begin
            pkt_in = pkt_ff + 1'b1;
         end else begin
            pkt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hdr_ff      <= '0;
         pkt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         hdr_ff      <= hdr_in;
         pkt_ff      <= pkt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_bus.operation;
         s1_byte_ff  <= req_bus.byte_value;
         s1_angle_ff <= req_bus.query_angle;
      end
      if (byte_go && !in_header && in_packet) begin
         pkt_bytes_ff[pkt_ff[lpdst_pkg::PKT_IDX_W-1:0]] <= s1_byte_ff;
      end
   end

endmodule

FILE: design/lpdst_table.sv
module lpdst_table (
   input  logic                     clock,
   input  logic                     reset,
   input  lpdst_pkg::tbl_req_type   tbl_req,
   input  logic                     take,
   output lpdst_pkg::tbl_stat_type  tbl_stat,
   output lpdst_pkg::res_type       res
);

   logic signed [lpdst_pkg::DIST_W-1:0] dist_mem [lpdst_pkg::ANGLE_COUNT];
   logic [lpdst_pkg::QUAL_W-1:0]        qual_mem [lpdst_pkg::ANGLE_COUNT];

   logic                                clearing_ff, clearing_in;
   logic [lpdst_pkg::ANGLE_W-1:0]       clr_ff, clr_in;

   logic                                m_valid_ff, m_valid_in;
   logic                                m_kind_ff;
   logic [lpdst_pkg::ANGLE_W-1:0]       m_angle_ff;
   logic signed [lpdst_pkg::DIST_W-1:0] m_dist_ff;
   logic [lpdst_pkg::QUAL_W-1:0]        m_qual_ff;
   logic signed [lpdst_pkg::DIST_W-1:0] rd_dist_ff;
   logic [lpdst_pkg::QUAL_W-1:0]        rd_qual_ff;

   logic                                load;
   logic                                we;
   logic [lpdst_pkg::ANGLE_W-1:0]       waddr;
   logic signed [lpdst_pkg::DIST_W-1:0] wdist;
   logic [lpdst_pkg::QUAL_W-1:0]        wqual;

   assign load       = tbl_req.wr_en || tbl_req.rd_en;
   assign m_valid_in = load || (m_valid_ff && !take);

   assign tbl_stat.clearing = clearing_ff;
   assign tbl_stat.free     = !m_valid_ff || take;

   // clear pass has the write port to itself
   assign we    = clearing_ff || tbl_req.wr_en;
   assign waddr = clearing_ff ? clr_ff : tbl_req.addr;
   assign wdist = clearing_ff ? lpdst_pkg::FALLBACK_DISTANCE_RESET : tbl_req.distance;
   assign wqual = clearing_ff ? lpdst_pkg::FALLBACK_QUALITY_RESET : tbl_req.qual;

   always_comb begin
      clearing_in = clearing_ff;
      clr_in      = clr_ff;
      if (clearing_ff) begin
         if (clr_ff == lpdst_pkg::ANGLE_W'(lpdst_pkg::ANGLE_COUNT - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         m_valid_ff  <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         m_valid_ff  <= m_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         dist_mem[waddr] <= wdist;
         qual_mem[waddr] <= wqual;
      end
      if (tbl_req.rd_en) begin
         rd_dist_ff <= dist_mem[tbl_req.addr];
         rd_qual_ff <= qual_mem[tbl_req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         m_kind_ff  <= tbl_req.rd_en ? lpdst_pkg::KIND_QUERY : lpdst_pkg::KIND_MEAS;
         m_angle_ff <= tbl_req.addr;
         m_dist_ff  <= tbl_req.distance;
         m_qual_ff  <= tbl_req.qual;
      end
   end

   always_comb begin
      res.valid    = m_valid_ff;
      res.kind     = m_kind_ff;
      res.angle    = m_angle_ff;
      res.distance = (m_kind_ff == lpdst_pkg::KIND_QUERY) ? rd_dist_ff : m_dist_ff;
      res.qual     = (m_kind_ff == lpdst_pkg::KIND_QUERY) ? rd_qual_ff : m_qual_ff;
   end

endmodule

FILE: design/lpdst_out.sv
module lpdst_out (
   input  logic                clock,
   input  logic                reset,
   input  lpdst_pkg::res_type  res,
   output logic                take,
   lpdst_rsp_if.source         rsp_bus
);

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff;
   logic [lpdst_pkg::ANGLE_W-1:0]       rsp_angle_ff;
   logic signed [lpdst_pkg::DIST_W-1:0] rsp_dist_ff;
   logic [lpdst_pkg::QUAL_W-1:0]        rsp_qual_ff;

   assign take         = res.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.result_kind   = rsp_kind_ff;
   assign rsp_bus.angle_deg     = rsp_angle_ff;
   assign rsp_bus.distance_mm   = rsp_dist_ff;
   assign rsp_bus.quality_level = rsp_qual_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_kind_ff  <= res.kind;
         rsp_angle_ff <= res.angle;
         rsp_dist_ff  <= res.distance;
         rsp_qual_ff  <= res.qual;
      end
   end

endmodule

FILE: design/lidar_packet_decoder_scan_table.sv
// Scan-table decoder for a rotating range sensor. One transaction (a received byte or an
// angle query) is accepted per clock unless the clearing pass or rsp_bus back-pressure holds
// it; a result passes the input register, the registered table read and the output register.
// The first HEADER_BYTES bytes after reset are dropped, then every five bytes form one
// measurement that is written into the 360-entry distance and quality tables and reported.
// After reset a clearing pass writes the reset values into the tables; no transaction is taken
// on req_bus during it, while csr_bus writes are accepted throughout.
module lidar_packet_decoder_scan_table #(
   parameter int HEADER_BYTES = 7
) (
   input  logic        clock,
   input  logic        reset,
   lpdst_req_if.sink   req_bus,
   lpdst_rsp_if.source rsp_bus,
   lpdst_csr_if.sink   csr_bus
);

   lpdst_pkg::cfg_type      cfg;
   lpdst_pkg::tbl_req_type  tbl_req;
   lpdst_pkg::tbl_stat_type tbl_stat;
   lpdst_pkg::res_type      res;
   logic                    take;

   lpdst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lpdst_decode #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .tbl_stat (tbl_stat),
      .tbl_req  (tbl_req)
   );

   lpdst_table u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl_req  (tbl_req),
      .take     (take),
      .tbl_stat (tbl_stat),
      .res      (res)
   );

   lpdst_out u_out (
      .clock   (clock),
      .reset   (reset),
      .res     (res),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_no_traffic_in_clear: assert property (@(posedge clock) disable iff (reset)
      (tbl_req.wr_en || tbl_req.rd_en) |-> !tbl_stat.clearing)
      else $error("table access during clearing pass");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      (tbl_req.wr_en || tbl_req.rd_en) |-> (tbl_req.addr < lpdst_pkg::ANGLE_COUNT))
      else $error("table address out of range");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (res.valid && !take) |=> (res.valid && $stable(res.angle) && $stable(res.kind)))
      else $error("table stage lost a result");

   a_rsp_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.angle_deg < lpdst_pkg::ANGLE_COUNT))
      else $error("result angle out of range");
`endif

endmodule
